// ===== rtl/core/mpqa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpqa_pkg
// Shared sizes, codes and item types of the array-based max priority queue.
// ----------------------------------------------------------------------------
package mpqa_pkg;

   localparam int CAPACITY = 8;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                     operation;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] removed_value;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] oldest_value;
      logic signed [DATA_W-1:0] newest_value;
   } rsp_type;

   // engine status seen by the channel logic
   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

// ===== rtl/core/max_priority_queue_array_top.sv =====
// ----------------------------------------------------------------------------
// max_priority_queue_array_top
// Bounded max priority queue kept unsorted in a small entry memory.
//
// req channel: operation (insert / remove largest) and value. Each item
// gives exactly one rsp item: status, removed value, count afterwards and
// the oldest and newest stored entries afterwards.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low. One item is in work at a time; req_stall is high while
// the engine is busy.
// Steps per item; the entry memory has a single read port:
//   insert: write, two peek reads, result
//   remove: max scan over all entries, then a shift-down pass from the
//           removed slot, then two peek reads; no scan or pass when the
//           queue is empty, and no peek reads when it is empty afterwards
// The result sits in an output register; the engine goes back to idle as
// soon as that register takes it, so the next item can be accepted while
// rsp_stall holds the previous result.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module max_priority_queue_array_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mpqa_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mpqa_pkg::rsp_type  rsp_data
);

   mpqa_pkg::eng_stat_type stat;
   mpqa_pkg::rsp_type      result;
   mpqa_pkg::rsp_type      rsp_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   start;
   logic                   load;

   assign req_stall = !stat.idle;
   assign start     = req_valid && stat.idle;
   assign load      = stat.done && (!rsp_valid_ff || !rsp_stall);

   mpqa_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .ack    (load),
      .stat   (stat),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/mpqa_engine.sv =====
// ----------------------------------------------------------------------------
// mpqa_engine
// Entry memory plus sequencer: append, max scan, shift-down and peek reads.
// ----------------------------------------------------------------------------
module mpqa_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  mpqa_pkg::req_type       req,
   input  logic                    ack,
   output mpqa_pkg::eng_stat_type  stat,
   output mpqa_pkg::rsp_type       result
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_SHIFT     = 3'd2;
   localparam logic [2:0] S_PEEK_OLD  = 3'd3;
   localparam logic [2:0] S_PEEK_NEW  = 3'd4;
   localparam logic [2:0] S_PEEK_WAIT = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   localparam int IDX_W  = mpqa_pkg::IDX_W;
   localparam int CNT_W  = mpqa_pkg::CNT_W;
   localparam int DATA_W = mpqa_pkg::DATA_W;

   logic signed [DATA_W-1:0] mem [mpqa_pkg::CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;

   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         ptr_ff, ptr_in;
   logic                     vld_ff, vld_in;
   logic [IDX_W-1:0]         dpos_ff, dpos_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]         bpos_ff, bpos_in;
   logic [mpqa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;
   logic signed [DATA_W-1:0] oldest_ff, oldest_in;
   logic signed [DATA_W-1:0] newest_ff, newest_in;

   logic                     issue;
   logic                     take;
   logic [IDX_W-1:0]         last_idx;
   logic signed [DATA_W-1:0] best_nx;
   logic [IDX_W-1:0]         bpos_nx;

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign issue    = (ptr_ff < cnt_ff);
   assign last_idx = IDX_W'(cnt_ff - CNT_W'(1));
   // strictly greater keeps the lowest slot on ties
   assign take     = vld_ff && ((dpos_ff == '0) || (rdata_ff > best_ff));
   assign best_nx  = take ? rdata_ff : best_ff;
   assign bpos_nx  = take ? dpos_ff : bpos_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      vld_in     = 1'b0;
      dpos_in    = dpos_ff;
      best_in    = best_ff;
      bpos_in    = bpos_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      oldest_in  = oldest_ff;
      newest_in  = newest_ff;
      rd_en      = 1'b0;
      rd_addr    = ptr_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = cnt_ff[IDX_W-1:0];
      wr_data    = req.value;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               removed_in = '0;
               status_in  = mpqa_pkg::ST_OK;
               state_in   = S_PEEK_OLD;
               if (req.operation == mpqa_pkg::OP_INSERT) begin
                  if (cnt_ff >= CNT_W'(mpqa_pkg::CAPACITY)) begin
                     status_in = mpqa_pkg::ST_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end else if (cnt_ff == '0) begin
                  status_in = mpqa_pkg::ST_EMPTY;
               end else begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_en   = issue;
            vld_in  = issue;
            dpos_in = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            best_in = best_nx;
            bpos_in = bpos_nx;
            if (vld_ff && (dpos_ff == last_idx)) begin
               removed_in = best_nx;
               ptr_in     = CNT_W'(bpos_nx) + CNT_W'(1);
               vld_in     = 1'b0;
               state_in   = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // read slot i+1, write it into slot i in the next cycle
            rd_en   = issue;
            vld_in  = issue;
            dpos_in = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = dpos_ff - IDX_W'(1);
               wr_data = rdata_ff;
            end
            if (!issue && !vld_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_PEEK_OLD;
            end
         end
         S_PEEK_OLD: begin
            if (cnt_ff == '0) begin
               oldest_in = '0;
               newest_in = '0;
               state_in  = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_PEEK_NEW;
            end
         end
         S_PEEK_NEW: begin
            rd_en     = 1'b1;
            rd_addr   = last_idx;
            oldest_in = rdata_ff;
            state_in  = S_PEEK_WAIT;
         end
         S_PEEK_WAIT: begin
            newest_in = rdata_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      dpos_ff    <= dpos_in;
      best_ff    <= best_in;
      bpos_ff    <= bpos_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      oldest_ff  <= oldest_in;
      newest_ff  <= newest_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);

   assign result.status        = status_ff;
   assign result.removed_value = removed_ff;
   assign result.count         = mpqa_pkg::COUNT_W'(cnt_ff);
   assign result.oldest_value  = oldest_ff;
   assign result.newest_value  = newest_ff;

endmodule
